>>> hdl/touch_pad_tap_hold_debouncer_assert.svh
// assertion macros for the touch pad debouncer
`ifndef TOUCH_PAD_TAP_HOLD_DEBOUNCER_ASSERT_SVH
`define TOUCH_PAD_TAP_HOLD_DEBOUNCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPTHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TPTHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tpthd_pkg.sv
package tpthd_pkg;

    localparam int PAD_W   = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;

    localparam logic [CFG_W-1:0] GLITCH_RESET = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RESET   = 16'd600;
    localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd1000;

    // event kinds
    localparam logic EVT_TAP  = 1'b0;
    localparam logic EVT_HOLD = 1'b1;

    // per-pad tracking entry
    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] raw_change_time;
        logic              stable_level;
        logic [TIME_W-1:0] press_start_time;
        logic              hold_done;
        logic [TIME_W-1:0] next_repeat_time;
    } pad_state_t;

endpackage

>>> hdl/tpthd_if.sv
interface tpthd_sample_if
    import tpthd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAD_W-1:0]  pad;
    logic              touched;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output pad, output touched, output time_ms, input ready);
    modport sink   (input valid, input pad, input touched, input time_ms, output ready);
endinterface

interface tpthd_event_if
    import tpthd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [PAD_W-1:0]  event_pad;
    logic [TIME_W-1:0] event_time;

    modport source (output valid, output event_kind, output event_pad, output event_time,
                    input ready);
    modport sink   (input valid, input event_kind, input event_pad, input event_time,
                    output ready);
endinterface

>>> hdl/tpthd_ram.sv
module tpthd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                     wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                     rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/touch_pad_tap_hold_debouncer.sv
// touch pad tap/hold debouncer: takes one raw sample request per cycle unless the update stage
// is stalled by a held output register, and returns at most one tap or hold event per sample
// (ram lookup, then update into the output register); requests on different or on the same
// pad may follow back to back, since the pad entry written by one sample is forwarded to the
// next; per-pad state lives in a ram of PAD_COUNT entries, and a per-pad valid flag cleared
// at reset makes every entry read as zero until first written, so no clearing pass runs after
// reset; samples for pads at or above PAD_COUNT pass through without effect or event; writes
// to unused indexes are dropped; the user must write the three millisecond settings through
// cfg_we/cfg_index/cfg_data only while no sample is in flight; the block does not enforce it
module touch_pad_tap_hold_debouncer
    import tpthd_pkg::*;
#(
    parameter int PAD_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tpthd_sample_if.sink         sample,
    tpthd_event_if.source        tap_event
);

    localparam int IDX_W   = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int STATE_W = $bits(pad_state_t);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] glitch_reg, glitch_next;
    logic [CFG_W-1:0] hold_reg,   hold_next;
    logic [CFG_W-1:0] repeat_reg, repeat_next;

    always_comb
    begin
        glitch_next = glitch_reg;
        hold_next   = hold_reg;
        repeat_next = repeat_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLITCH: glitch_next = cfg_data;
                CFG_HOLD:   hold_next   = cfg_data;
                CFG_REPEAT: repeat_next = cfg_data;
                default:    ;  // unused index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_reg <= GLITCH_RESET;
            hold_reg   <= HOLD_RESET;
            repeat_reg <= REPEAT_RESET;
        end
        else
        begin
            glitch_reg <= glitch_next;
            hold_reg   <= hold_next;
            repeat_reg <= repeat_next;
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s1_valid_next;
    logic [PAD_W-1:0]     s1_pad_reg;
    logic                 s1_touched_reg;
    logic [TIME_W-1:0]    s1_time_reg;
    logic                 s1_in_range_reg;
    logic                 s1_entry_valid_reg;
    logic                 fwd_valid_reg, fwd_valid_next;
    pad_state_t           fwd_data_reg;
    logic [PAD_COUNT-1:0] pad_valid_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg;
    logic [PAD_W-1:0]     out_pad_reg;
    logic [TIME_W-1:0]    out_time_reg;

    logic                 s1_has_result;
    logic                 s1_move;
    logic                 sample_accept;
    logic                 in_range;
    logic [IDX_W-1:0]     in_idx;
    logic [IDX_W-1:0]     s1_idx;
    logic                 ram_we;
    logic [STATE_W-1:0]   ram_rdata;

    assign in_idx   = sample.pad[IDX_W-1:0];
    assign s1_idx   = s1_pad_reg[IDX_W-1:0];
    assign in_range = ({1'b0, sample.pad} < (PAD_W + 1)'(PAD_COUNT));

    // the update stage retires unless it has an event and the output register is held
    assign s1_move = s1_valid_reg && (!s1_has_result || !out_valid_reg || tap_event.ready);
    assign sample.ready  = !s1_valid_reg || s1_move;
    assign sample_accept = sample.valid && sample.ready;

    // pad entry is written back as the update stage retires
    assign ram_we = s1_move && s1_in_range_reg;

    // ------------------------------------------------------------------
    // pad state memory: lookup on request, write back from the update stage later
    // ------------------------------------------------------------------
    pad_state_t state_next;

    tpthd_ram #(
        .DATA_W (STATE_W),
        .DEPTH  (PAD_COUNT)
    ) u_pad_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (s1_idx),
        .wdata  (state_next),
        .re     (sample_accept && in_range),
        .raddr  (in_idx),
        .rdata  (ram_rdata)
    );

    // entry seen by the update stage: forwarded write if the previous request hit the
    // same pad in the cycle of the lookup, zero if never written since reset
    pad_state_t cur;

    always_comb
    begin
        if (fwd_valid_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            cur = pad_state_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // update logic for one sample
    // ------------------------------------------------------------------
    logic              raw_chg;
    logic [TIME_W-1:0] rct;
    logic [TIME_W-1:0] now_minus_rct;
    logic [TIME_W-1:0] now_minus_press;
    logic [TIME_W-1:0] press_dur;
    logic              stable_take;
    logic              press_new;
    logic [TIME_W-1:0] press1;
    logic              hold_done1;
    logic              stable1;
    logic              rel_evt;
    logic              rel_kind;
    logic              held;
    logic              hold_first;
    logic              hold_rep;
    logic [TIME_W-1:0] repeat_diff;

    always_comb
    begin
        raw_chg = (s1_touched_reg != cur.raw_level);
        rct     = raw_chg ? s1_time_reg : cur.raw_change_time;

        // all differences come from the stored entry in parallel
        now_minus_rct = raw_chg ? '0 : (s1_time_reg - cur.raw_change_time);
        press_dur     = rct - cur.press_start_time;
        repeat_diff   = s1_time_reg - cur.next_repeat_time;

        // debounced level follows raw once it has persisted for the glitch time
        stable_take = (s1_touched_reg != cur.stable_level) &&
                      (now_minus_rct >= {{(TIME_W - CFG_W){1'b0}}, glitch_reg});
        stable1     = stable_take ? s1_touched_reg : cur.stable_level;
        press_new   = stable_take && s1_touched_reg;
        press1      = press_new ? rct : cur.press_start_time;
        hold_done1  = press_new ? 1'b0 : cur.hold_done;
        now_minus_press = press_new ? now_minus_rct : (s1_time_reg - cur.press_start_time);

        // accepted release with no hold fired yet
        rel_evt  = stable_take && !s1_touched_reg && !cur.hold_done;
        rel_kind = (press_dur < {{(TIME_W - CFG_W){1'b0}}, hold_reg}) ? EVT_TAP : EVT_HOLD;

        // while held: first hold at threshold, then repeats when the signed gap is >= 0
        held       = stable1 && s1_touched_reg;
        hold_first = held && !hold_done1 &&
                     (now_minus_press >= {{(TIME_W - CFG_W){1'b0}}, hold_reg});
        hold_rep   = held && hold_done1 && !repeat_diff[TIME_W-1];

        state_next.raw_level        = s1_touched_reg;
        state_next.raw_change_time  = rct;
        state_next.stable_level     = stable1;
        state_next.press_start_time = press1;
        state_next.hold_done        = hold_done1 || hold_first;
        if (hold_first)
        begin
            state_next.next_repeat_time = press1 + {{(TIME_W - CFG_W){1'b0}}, hold_reg}
                                                 + {{(TIME_W - CFG_W){1'b0}}, repeat_reg};
        end
        else if (hold_rep)
        begin
            state_next.next_repeat_time = cur.next_repeat_time
                                        + {{(TIME_W - CFG_W){1'b0}}, repeat_reg};
        end
        else
        begin
            state_next.next_repeat_time = cur.next_repeat_time;
        end

        s1_has_result = s1_in_range_reg && (rel_evt || hold_first || hold_rep);
    end

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        if (sample_accept)
        begin
            s1_valid_next  = 1'b1;
            // same-cycle write to the pad being looked up: ram returns stale data
            fwd_valid_next = ram_we && in_range && (s1_idx == in_idx);
        end
        else if (s1_move)
        begin
            s1_valid_next  = 1'b0;
            fwd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            pad_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            if (ram_we)
            begin
                pad_valid_reg[s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_pad_reg         <= sample.pad;
            s1_touched_reg     <= sample.touched;
            s1_time_reg        <= sample.time_ms;
            s1_in_range_reg    <= in_range;
            s1_entry_valid_reg <= in_range ? pad_valid_reg[in_idx] : 1'b0;
        end
        if (ram_we)
        begin
            fwd_data_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move && s1_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (tap_event.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_has_result)
        begin
            out_pad_reg <= s1_pad_reg;
            if (rel_evt)
            begin
                // release events carry the raw change time
                out_kind_reg <= rel_kind;
                out_time_reg <= rct;
            end
            else
            begin
                out_kind_reg <= EVT_HOLD;
                out_time_reg <= s1_time_reg;
            end
        end
    end

    assign tap_event.valid      = out_valid_reg;
    assign tap_event.event_kind = out_kind_reg;
    assign tap_event.event_pad  = out_pad_reg;
    assign tap_event.event_time = out_time_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "touch_pad_tap_hold_debouncer_assert.svh"

    `TPTHD_ASSERT_NOW(a_we_in_range, ram_we, s1_valid_reg && s1_in_range_reg, "pad write out of range")
    `TPTHD_ASSERT_NOW(a_fwd_occupied, fwd_valid_reg, s1_valid_reg, "forward flag with empty stage")
    `TPTHD_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_move, s1_valid_reg && $stable(cur), "stalled entry changed")
    `TPTHD_ASSERT_NEXT(a_event_lands, s1_move && s1_has_result, out_valid_reg, "event lost at output")

endmodule
